// ===== hw/rtl/lic_pkg.sv =====
package lic_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int POINT_LIMIT    = 16;

    // Numerator of one term: 64x32 magnitude product shifted left by 8.
    localparam int NUM_W  = 104;
    localparam int DIV_CW = 7;

    localparam logic [63:0]        ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0]        S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0]        S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;
    localparam logic [47:0]        SAT48_MAX = {1'b0, {47{1'b1}}};
    localparam logic [47:0]        SAT48_MIN = {1'b1, {47{1'b0}}};

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;
    localparam logic [1:0] ST_DROP = 2'd3;

    typedef enum logic [4:0] {
        S_LOAD, S_CLR,
        S_DUPI, S_DUPI2, S_DUPJ,
        S_BJ, S_BJ2, S_BI, S_BI2, S_BK, S_BLD, S_BWR, S_DEN, S_DWR,
        S_M0, S_M1, S_M2,
        S_AK, S_ALD, S_DIVI, S_DIV, S_AWR, S_JNXT,
        S_CHK, S_CHK2, S_ORD, S_OLD, S_OWT
    } t_state;

    typedef enum logic [1:0] {
        MM_BASIS, MM_DEN, MM_NUM
    } t_mmode;

    typedef struct packed {
        logic [63:0] val;
        logic        sat;
    } t_sres;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] mag33(input logic [32:0] v);
        logic [32:0] m;
        m = v[32] ? (~v + 33'd1) : v;
        return m[31:0];
    endfunction

    // Signed 64-bit value from sign and magnitude, saturating.
    function automatic t_sres from_mag(input logic neg, input logic [NUM_W-1:0] m);
        t_sres r;
        r.sat = 1'b0;
        r.val = m[63:0];
        if (neg) begin
            if (m[NUM_W-1:64] != '0 || (m[63] && m[62:0] != '0)) begin
                r.val = S64_MIN;
                r.sat = 1'b1;
            end else begin
                r.val = ~m[63:0] + 64'd1;
            end
        end else if (m[NUM_W-1:63] != '0) begin
            r.val = S64_MAX;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    function automatic t_sres sadd(input logic [63:0] a, input logic [63:0] b);
        t_sres       r;
        logic [64:0] s;
        s     = {a[63], a} + {b[63], b};
        r.sat = s[64] != s[63];
        r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/lagrange_interpolation_coefficients.sv =====
// Lagrange interpolating polynomial coefficients, signed fixed point.
// Input channel: one sample point per transfer (x, y in Q16.16). The
// transfer with i_last_point high closes the set and starts the solve.
// Points beyond capacity are dropped; the run gets status 3 unless x repeats.
// Output channel: one transfer per coefficient, degree 0 upward, Q24.24,
// o_last_coeff high on the highest degree. All carry the same status.
// Input: a point that is not last is taken without a stall. The final point
// holds o_stall high for the whole solve and the output phase. Every basis,
// denominator and numerator term goes through one shared multiply (two
// 32x32 partial products and their sum), each coefficient term through
// a restoring divider that retires one quotient bit per cycle (104 bits).
// Points, basis product and accumulators live in three single-read RAMs.
// The output register holds each coefficient until the receiver takes it;
// while it is shown and i_stall is high, the block waits with all frozen.
// Reset (synchronous, i_rst_n low) empties the point store and clears the
// drop flag; no clearing pass runs. The accumulators are swept to zero at
// the start of every solve, one entry per point.
module lagrange_interpolation_coefficients #(
    parameter int MAX_POINTS = lic_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_last_point,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_coeff_index,
    output logic signed [47:0] o_coefficient,
    output logic               o_last_coeff,
    output logic [1:0]         o_status
);

    localparam int CAP = (MAX_POINTS < lic_pkg::POINT_LIMIT) ? MAX_POINTS
                                                               : lic_pkg::POINT_LIMIT;
    localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CW  = $clog2(CAP + 1);
    localparam logic [CW-1:0] C_ONE = CW'(1);
    localparam logic [CW-1:0] C_CAP = CW'(CAP);

    lic_pkg::t_state r_state, n_state;
    lic_pkg::t_mmode r_mode;

    // control
    logic [CW-1:0] r_count, r_n, r_i, r_j, r_k, r_deg;
    logic          r_drop, r_dup, r_sat;
    logic [lic_pkg::DIV_CW-1:0] r_dcnt;

    // datapath
    logic signed [31:0] r_xi, r_xj, r_yj;
    logic [63:0] r_den, r_dmag, r_prev, r_old, r_acc;
    logic [63:0] r_ma;
    logic [31:0] r_mb;
    logic        r_mneg;
    logic [63:0] r_plo, r_phi;
    logic [95:0] r_prod;
    logic [lic_pkg::NUM_W-1:0] r_num;
    logic [63:0] r_rem;

    // output register
    logic        r_ovalid, r_olast;
    logic [3:0]  r_oidx;
    logic [47:0] r_ocoef;
    logic [1:0]  r_ostat;

    // RAM ports
    logic          pt_we, bs_we, ac_we;
    logic [AW-1:0] pt_waddr, pt_raddr, bs_waddr, ac_waddr;
    logic [63:0]   pt_wdata, bs_wdata, ac_wdata;
    logic [63:0]   pt_rdata, bs_rdata, ac_rdata;

    logic          in_xfer;
    logic [CW-1:0] w_cnt_next;
    lic_pkg::t_sres w_mres, w_bsum, w_qres, w_asum;
    logic [63:0]   w_bold;
    logic [32:0]   w_diff;
    logic [64:0]   w_rem2;
    logic          w_ge;
    logic signed [63:0] w_acc_s;

    lic_ram #(.WIDTH(64), .DEPTH(CAP)) u_pt_ram (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_waddr), .i_wdata(pt_wdata),
        .i_raddr(pt_raddr), .o_rdata(pt_rdata)
    );

    lic_ram #(.WIDTH(64), .DEPTH(CAP)) u_basis_ram (
        .i_clk(i_clk), .i_we(bs_we), .i_waddr(bs_waddr), .i_wdata(bs_wdata),
        .i_raddr(r_k[AW-1:0]), .o_rdata(bs_rdata)
    );

    lic_ram #(.WIDTH(64), .DEPTH(CAP)) u_acc_ram (
        .i_clk(i_clk), .i_we(ac_we), .i_waddr(ac_waddr), .i_wdata(ac_wdata),
        .i_raddr(r_k[AW-1:0]), .o_rdata(ac_rdata)
    );

    assign in_xfer    = i_valid && !o_stall;
    assign w_cnt_next = (r_count < C_CAP) ? r_count + C_ONE : r_count;

    // shared arithmetic
    assign w_mres  = lic_pkg::from_mag(r_mneg, {24'd0, r_prod[95:16]});
    assign w_bsum  = lic_pkg::sadd(r_prev, w_mres.val);
    assign w_qres  = lic_pkg::from_mag(r_mneg, r_num);
    assign w_asum  = lic_pkg::sadd(r_acc, w_qres.val);
    assign w_bold  = (r_k > r_deg) ? 64'd0 : bs_rdata;
    assign w_diff  = {r_xj[31], r_xj} - {r_xi[31], r_xi};
    assign w_rem2  = {r_rem, r_num[lic_pkg::NUM_W-1]};
    assign w_ge    = w_rem2 >= {1'b0, r_dmag};
    assign w_acc_s = $signed(ac_rdata);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lic_pkg::S_LOAD:  if (in_xfer && i_last_point) n_state = lic_pkg::S_CLR;
            lic_pkg::S_CLR:   if (r_k + C_ONE == r_n) n_state = lic_pkg::S_DUPI;
            lic_pkg::S_DUPI: begin
                if (r_i + C_ONE >= r_n) begin
                    n_state = r_dup ? lic_pkg::S_ORD : lic_pkg::S_BJ;
                end else begin
                    n_state = lic_pkg::S_DUPI2;
                end
            end
            lic_pkg::S_DUPI2: n_state = lic_pkg::S_DUPJ;
            lic_pkg::S_DUPJ:  if (r_j + C_ONE == r_n) n_state = lic_pkg::S_DUPI;
            lic_pkg::S_BJ:    n_state = lic_pkg::S_BJ2;
            lic_pkg::S_BJ2:   n_state = lic_pkg::S_BI;
            lic_pkg::S_BI: begin
                if (r_i == r_n) begin
                    n_state = (r_den == '0) ? lic_pkg::S_JNXT : lic_pkg::S_AK;
                end else if (r_i != r_j) begin
                    n_state = lic_pkg::S_BI2;
                end
            end
            lic_pkg::S_BI2:   n_state = lic_pkg::S_BK;
            lic_pkg::S_BK:    n_state = lic_pkg::S_BLD;
            lic_pkg::S_BLD:   n_state = lic_pkg::S_M0;
            lic_pkg::S_M0:    n_state = lic_pkg::S_M1;
            lic_pkg::S_M1:    n_state = lic_pkg::S_M2;
            lic_pkg::S_M2: begin
                unique case (r_mode)
                    lic_pkg::MM_BASIS: n_state = lic_pkg::S_BWR;
                    lic_pkg::MM_DEN:   n_state = lic_pkg::S_DWR;
                    default:           n_state = lic_pkg::S_DIVI;
                endcase
            end
            lic_pkg::S_BWR:   n_state = (r_k == r_deg + C_ONE) ? lic_pkg::S_DEN : lic_pkg::S_BK;
            lic_pkg::S_DEN:   n_state = lic_pkg::S_M0;
            lic_pkg::S_DWR:   n_state = lic_pkg::S_BI;
            lic_pkg::S_AK:    n_state = lic_pkg::S_ALD;
            lic_pkg::S_ALD:   n_state = lic_pkg::S_M0;
            lic_pkg::S_DIVI:  n_state = lic_pkg::S_DIV;
            lic_pkg::S_DIV: begin
                if (r_dcnt == lic_pkg::DIV_CW'(lic_pkg::NUM_W - 1)) n_state = lic_pkg::S_AWR;
            end
            lic_pkg::S_AWR:   n_state = (r_k == r_deg) ? lic_pkg::S_JNXT : lic_pkg::S_AK;
            lic_pkg::S_JNXT:  n_state = (r_j + C_ONE == r_n) ? lic_pkg::S_CHK : lic_pkg::S_BJ;
            lic_pkg::S_CHK:   n_state = lic_pkg::S_CHK2;
            lic_pkg::S_CHK2:  n_state = (r_k + C_ONE == r_n) ? lic_pkg::S_ORD : lic_pkg::S_CHK;
            lic_pkg::S_ORD:   n_state = lic_pkg::S_OLD;
            lic_pkg::S_OLD:   n_state = lic_pkg::S_OWT;
            lic_pkg::S_OWT: begin
                if (!i_stall) begin
                    n_state = (r_k + C_ONE == r_n) ? lic_pkg::S_LOAD : lic_pkg::S_ORD;
                end
            end
            default:          n_state = lic_pkg::S_LOAD;
        endcase
    end

    // RAM control and handshake
    always_comb begin
        o_stall  = r_state != lic_pkg::S_LOAD;
        pt_we    = in_xfer && (r_count < C_CAP);
        pt_waddr = r_count[AW-1:0];
        pt_wdata = {i_point_y, i_point_x};
        pt_raddr = r_i[AW-1:0];
        bs_we    = 1'b0;
        bs_waddr = r_k[AW-1:0];
        bs_wdata = w_bsum.val;
        ac_we    = 1'b0;
        ac_waddr = r_k[AW-1:0];
        ac_wdata = w_asum.val;
        unique case (r_state)
            lic_pkg::S_DUPI2: pt_raddr = r_j[AW-1:0];
            lic_pkg::S_DUPJ:  pt_raddr = AW'(r_j + C_ONE);
            lic_pkg::S_BJ:    pt_raddr = r_j[AW-1:0];
            lic_pkg::S_BJ2: begin
                bs_we    = 1'b1;
                bs_waddr = '0;
                bs_wdata = lic_pkg::ONE_Q32;
            end
            lic_pkg::S_BWR:   bs_we = 1'b1;
            lic_pkg::S_CLR: begin
                ac_we    = 1'b1;
                ac_wdata = '0;
            end
            lic_pkg::S_AWR:   ac_we = 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lic_pkg::S_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_count <= w_cnt_next;
                if (r_count == C_CAP) r_drop <= 1'b1;
            end
            if (r_state == lic_pkg::S_OLD) r_ovalid <= 1'b1;
            if (r_state == lic_pkg::S_OWT && !i_stall) begin
                r_ovalid <= 1'b0;
                // run complete: empty the store
                if (r_k + C_ONE == r_n) begin
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            lic_pkg::S_LOAD: begin
                r_n   <= w_cnt_next;
                r_k   <= '0;
                r_i   <= '0;
                r_dup <= 1'b0;
                r_sat <= 1'b0;
            end
            lic_pkg::S_CLR:  r_k <= (r_k + C_ONE == r_n) ? '0 : r_k + C_ONE;
            lic_pkg::S_DUPI: begin
                if (r_i + C_ONE >= r_n) begin
                    r_j <= '0;
                    r_k <= '0;
                end else begin
                    r_j <= r_i + C_ONE;
                end
            end
            lic_pkg::S_DUPI2: r_xi <= pt_rdata[31:0];
            lic_pkg::S_DUPJ: begin
                if (pt_rdata[31:0] == r_xi) r_dup <= 1'b1;
                if (r_j + C_ONE == r_n) r_i <= r_i + C_ONE;
                else                    r_j <= r_j + C_ONE;
            end
            lic_pkg::S_BJ2: begin
                r_xj  <= pt_rdata[31:0];
                r_yj  <= pt_rdata[63:32];
                r_deg <= '0;
                r_den <= lic_pkg::ONE_Q32;
                r_i   <= '0;
            end
            lic_pkg::S_BI: begin
                if (r_i == r_n) begin
                    r_k    <= '0;
                    r_dmag <= lic_pkg::mag64(r_den);
                    if (r_den == '0) r_sat <= 1'b1;
                end else if (r_i == r_j) begin
                    r_i <= r_i + C_ONE;
                end
            end
            lic_pkg::S_BI2: begin
                r_xi   <= pt_rdata[31:0];
                r_k    <= '0;
                r_prev <= '0;
            end
            lic_pkg::S_BLD: begin
                // multiply by -x_i: negative when x_i is positive
                r_old  <= w_bold;
                r_ma   <= lic_pkg::mag64(w_bold);
                r_mb   <= lic_pkg::mag32(r_xi);
                r_mneg <= w_bold[63] ^ (!r_xi[31] && r_xi != '0);
                r_mode <= lic_pkg::MM_BASIS;
            end
            lic_pkg::S_M0: r_plo  <= r_ma[31:0] * r_mb;
            lic_pkg::S_M1: r_phi  <= r_ma[63:32] * r_mb;
            lic_pkg::S_M2: r_prod <= {r_phi, 32'd0} + {32'd0, r_plo};
            lic_pkg::S_BWR: begin
                r_prev <= r_old;
                if (w_mres.sat || w_bsum.sat) r_sat <= 1'b1;
                if (r_k == r_deg + C_ONE) r_deg <= r_deg + C_ONE;
                else                      r_k   <= r_k + C_ONE;
            end
            lic_pkg::S_DEN: begin
                r_ma   <= lic_pkg::mag64(r_den);
                r_mb   <= lic_pkg::mag33(w_diff);
                r_mneg <= r_den[63] ^ w_diff[32];
                r_mode <= lic_pkg::MM_DEN;
            end
            lic_pkg::S_DWR: begin
                r_den <= w_mres.val;
                if (w_mres.sat) r_sat <= 1'b1;
                r_i <= r_i + C_ONE;
            end
            lic_pkg::S_ALD: begin
                r_acc  <= ac_rdata;
                r_ma   <= lic_pkg::mag64(bs_rdata);
                r_mb   <= lic_pkg::mag32(r_yj);
                r_mneg <= bs_rdata[63] ^ r_yj[31] ^ r_den[63];
                r_mode <= lic_pkg::MM_NUM;
            end
            lic_pkg::S_DIVI: begin
                r_num  <= {r_prod, 8'd0};
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            lic_pkg::S_DIV: begin
                // restoring step: quotient bits shift in behind the numerator
                r_rem  <= w_ge ? 64'(w_rem2 - {1'b0, r_dmag}) : w_rem2[63:0];
                r_num  <= {r_num[lic_pkg::NUM_W-2:0], w_ge};
                r_dcnt <= r_dcnt + 1'b1;
            end
            lic_pkg::S_AWR: begin
                if (w_qres.sat || w_asum.sat) r_sat <= 1'b1;
                if (r_k != r_deg) r_k <= r_k + C_ONE;
            end
            lic_pkg::S_JNXT: begin
                if (r_j + C_ONE == r_n) r_k <= '0;
                else                    r_j <= r_j + C_ONE;
            end
            lic_pkg::S_CHK2: begin
                if (w_acc_s > lic_pkg::OUT_MAX || w_acc_s < lic_pkg::OUT_MIN) r_sat <= 1'b1;
                r_k <= (r_k + C_ONE == r_n) ? '0 : r_k + C_ONE;
            end
            lic_pkg::S_OLD: begin
                r_oidx  <= 4'(r_k);
                r_olast <= r_k + C_ONE == r_n;
                if (r_dup) begin
                    r_ocoef <= '0;
                    r_ostat <= lic_pkg::ST_DUP;
                end else begin
                    if (w_acc_s > lic_pkg::OUT_MAX)      r_ocoef <= lic_pkg::SAT48_MAX;
                    else if (w_acc_s < lic_pkg::OUT_MIN) r_ocoef <= lic_pkg::SAT48_MIN;
                    else                                 r_ocoef <= ac_rdata[47:0];
                    if (r_drop)     r_ostat <= lic_pkg::ST_DROP;
                    else if (r_sat) r_ostat <= lic_pkg::ST_SAT;
                    else            r_ostat <= lic_pkg::ST_OK;
                end
            end
            lic_pkg::S_OWT: if (!i_stall) r_k <= r_k + C_ONE;
            default: ;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_coeff_index = r_oidx;
    assign o_coefficient = r_ocoef;
    assign o_last_coeff  = r_olast;
    assign o_status      = r_ostat;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_CAP)
        else $error("point count beyond capacity");

    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == lic_pkg::S_OWT)
        else $error("result shown outside output wait");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_k < r_n)
        else $error("coefficient index beyond point count");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_coeff && !i_stall) |=> (r_count == '0 && !r_drop
            && r_state == lic_pkg::S_LOAD))
        else $error("store not emptied after last coefficient");

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lic_pkg::S_CLR) |-> r_n != '0)
        else $error("solve started with no points");
`endif

endmodule

// ===== hw/rtl/lic_ram.sv =====
module lic_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/lagrange_interpolation_coefficients_tb.sv =====
`timescale 1ns / 100ps

module lagrange_interpolation_coefficients_tb;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 20_000_000;

    // One emitted coefficient as the block should present it.
    typedef struct {
        logic [3:0]  index;
        logic [47:0] value;
        logic        last;
        logic [1:0]  status;
    } t_coeff;

    // Exact fixed-point solver. It mirrors the arithmetic of the block: every
    // product, shift and quotient is formed on magnitudes and truncated toward
    // zero, and every overshoot of the signed 64-bit range saturates.
    class coeff_scoreboard;
        logic signed [63:0] xs[CAPACITY];
        logic signed [63:0] ys[CAPACITY];
        int                 count;
        bit                 dropped;
        bit                 sat_hit;
        t_coeff             pending[$];
        int                 errors;

        function void clear_points();
            count   = 0;
            dropped = 0;
            sat_hit = 0;
        endfunction

        // Magnitude of a signed 64-bit value; -2^63 keeps its bit pattern.
        function logic [63:0] mag(logic signed [63:0] v);
            return v < 0 ? -v : v;
        endfunction

        function logic signed [63:0] signed_of(bit neg, logic [191:0] m);
            if (neg) begin
                if (m > 192'h8000_0000_0000_0000) begin
                    sat_hit = 1;
                    return 64'sh8000_0000_0000_0000;
                end
                return -m[63:0];
            end
            if (m > 192'h7FFF_FFFF_FFFF_FFFF) begin
                sat_hit = 1;
                return 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            return m[63:0];
        endfunction

        function logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63]) begin
                sat_hit = 1;
                return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            return s[63:0];
        endfunction

        function logic signed [63:0] mul_q16(logic signed [63:0] a, logic signed [63:0] b);
            logic [191:0] p;
            p = {128'd0, mag(a)} * {128'd0, mag(b)};
            return signed_of((a < 0) != (b < 0), p >> 16);
        endfunction

        function void add_basis_term(ref logic signed [63:0] acc[CAPACITY], int j);
            logic signed [63:0] prod[CAPACITY + 1];
            logic signed [63:0] den, negx;
            logic [191:0]       num;
            int                 deg;
            bit                 neg;
            deg     = 0;
            den     = lic_pkg::ONE_Q32;
            prod[0] = lic_pkg::ONE_Q32;
            for (int i = 0; i < count; i++) begin
                if (i == j) continue;
                negx = -xs[i];
                prod[deg + 1] = 0;
                for (int k = deg + 1; k > 0; k--)
                    prod[k] = add_sat(prod[k - 1], mul_q16(prod[k], negx));
                prod[0] = mul_q16(prod[0], negx);
                deg++;
                den = mul_q16(den, xs[j] - xs[i]);
            end
            // A denominator truncated to zero counts as saturation; drop the term.
            if (den == 0) begin
                sat_hit = 1;
                return;
            end
            for (int k = 0; k <= deg; k++) begin
                num = ({128'd0, mag(prod[k])} * {128'd0, mag(ys[j])}) << 8;
                neg = ((prod[k] < 0) != (ys[j] < 0)) != (den < 0);
                acc[k] = add_sat(acc[k], signed_of(neg, num / {128'd0, mag(den)}));
            end
        endfunction

        // Note an accepted point; on the closing point predict all coefficients.
        function void note_point(logic [31:0] x, logic [31:0] y, logic last);
            logic signed [63:0] acc[CAPACITY];
            logic signed [63:0] v;
            logic [1:0]         st;
            bit                 dup;
            t_coeff             c;
            if (count < CAPACITY) begin
                xs[count] = $signed(x);
                ys[count] = $signed(y);
                count++;
            end else begin
                dropped = 1;
            end
            if (!last) return;
            sat_hit = 0;
            dup     = 0;
            foreach (acc[k]) acc[k] = 0;
            for (int i = 0; i < count; i++)
                for (int j = i + 1; j < count; j++)
                    if (xs[i] == xs[j]) dup = 1;
            if (!dup)
                for (int j = 0; j < count; j++) add_basis_term(acc, j);
            for (int k = 0; k < count; k++) begin
                v = dup ? 64'sd0 : acc[k];
                if (v > lic_pkg::OUT_MAX) begin v = lic_pkg::OUT_MAX; sat_hit = 1; end
                if (v < lic_pkg::OUT_MIN) begin v = lic_pkg::OUT_MIN; sat_hit = 1; end
                acc[k] = v;
            end
            st = dup ? lic_pkg::ST_DUP : (dropped ? lic_pkg::ST_DROP
                                                  : (sat_hit ? lic_pkg::ST_SAT
                                                             : lic_pkg::ST_OK));
            for (int k = 0; k < count; k++) begin
                c.index  = k[3:0];
                c.value  = acc[k][47:0];
                c.last   = (k + 1 == count);
                c.status = st;
                pending.push_back(c);
            end
            clear_points();
        endfunction

        function void check_coeff(logic [3:0] idx, logic [47:0] val, logic last,
                                  logic [1:0] st);
            t_coeff c;
            if (pending.size() == 0) begin
                $error("unexpected coefficient index %0d value %h", idx, val);
                errors++;
                return;
            end
            c = pending.pop_front();
            if (idx !== c.index) begin
                $error("coeff_index: expected %0d, got %0d", c.index, idx);
                errors++;
            end
            if (val !== c.value) begin
                $error("coefficient: expected %h, got %h", c.value, val);
                errors++;
            end
            if (last !== c.last) begin
                $error("last_coeff: expected %0b, got %0b", c.last, last);
                errors++;
            end
            if (st !== c.status) begin
                $error("status: expected %0d, got %0d", c.status, st);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;
    logic               out_valid;
    logic               out_stall;
    logic [3:0]         coeff_index;
    logic signed [47:0] coefficient;
    logic               last_coeff;
    logic [1:0]         coeff_status;

    coeff_scoreboard board;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              cycles;

    lagrange_interpolation_coefficients DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_point_x     (point_x),
        .i_point_y     (point_y),
        .i_last_point  (last_point),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_coeff_index (coeff_index),
        .o_coefficient (coefficient),
        .o_last_coeff  (last_coeff),
        .o_status      (coeff_status)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter; end the run if the block hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stall at random, check every accepted coefficient.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_coeff(coeff_index, coefficient, last_coeff, coeff_status);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Present one point and hold it until the transfer completes. Random idle
    // cycles go in front, so the payload never changes while stalled. Valid
    // stays high after the transfer until the next idle cycle or a drain.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        point_x    <= x;
        point_y    <= y;
        last_point <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_point(x, y, last);
    endtask

    // Drain: drop valid and wait for every predicted coefficient.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    // Random point: mostly modest magnitudes so the solve stays in range,
    // sometimes full-width values.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(2 * 65536 * 8)) - 65536 * 8;
            default: return $signed($urandom_range(2 * 65536 * 4)) - 65536 * 4;
        endcase
    endfunction

    // Send a set of n points with distinct abscissas unless a repeat is wanted.
    task automatic send_set(int n, bit allow_dup);
        logic [31:0] x;
        logic [31:0] used[$];
        for (int i = 0; i < n; i++) begin
            do begin
                x = rand_coord();
            end while (!allow_dup && (x inside {used}));
            if (allow_dup && used.size() > 0 && $urandom_range(3) == 0)
                x = used[$urandom_range(used.size() - 1)];
            used.push_back(x);
            send_point(x, rand_coord(), i == n - 1);
        end
    endtask

    initial begin
        int sent;
        board          = new();
        board.errors   = 0;
        board.clear_points();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        point_x        = '0;
        point_y        = '0;
        last_point     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single point, field extremes, a line, a duplicate pair.
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_point(32'h0001_0000, 32'h0002_0000, 1'b0);
        send_point(32'h0002_0000, 32'h0004_0000, 1'b1);
        send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 32'h0001_0000, 1'b1);
        // Tiny spacing: abscissas one LSB apart give a tiny denominator.
        send_point(32'h0000_0001, 32'h0001_0000, 1'b0);
        send_point(32'h0000_0002, 32'h0001_0000, 1'b1);
        // Hold off until the block has emptied before the capacity case.
        wait_drained();
        // Overfill: eighteen points, the last two dropped.
        for (int i = 0; i < 18; i++)
            send_point(i * 32'h0000_4000, $urandom, i == 17);
        wait_drained();

        // Random sets through the four idling phases.
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 3 ? 26 : 77) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 26 : 77) : 0;
            for (int s = 0; s < 16; s++) begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 5);
                send_set(n, $urandom_range(7) == 0);
                sent += n;
            end
            // Pause the sender until all results of this phase are back.
            wait_drained();
        end
        // Top up with three-point sets.
        while (sent < 300) begin
            send_set(3, 1'b0);
            sent += 3;
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== lagrange_interpolation_coefficients.f =====
hw/rtl/lic_pkg.sv
hw/rtl/lic_ram.sv
hw/rtl/lagrange_interpolation_coefficients.sv
bench/lagrange_interpolation_coefficients_tb.sv
